/* sv/ffbta_pkg.sv */
package ffbta_pkg;

    localparam int unsigned REQ_W = 9;
    localparam int unsigned OFF_W = 9;
    localparam int unsigned ACT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_ALLOC_EVAL,
        ST_WR_HDR,
        ST_WR_FTR,
        ST_WR_REST,
        ST_FREE_RD,
        ST_FREE_EVAL,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_HDR,
        WR_FTR,
        WR_REST,
        WR_FREE,
        WR_CLR
    } wr_sel_t;

    typedef struct packed {
        logic    load_in;
        logic    walk_adv;
        logic    hit_latch;
        wr_sel_t wr_sel;
        logic    res_load;
        logic    res_ok;
    } cmd_t;

    typedef struct packed {
        logic walk_end;
        logic hit;
        logic split;
        logic free_bad;
        logic rd_alloc;
        logic clr_last;
    } status_t;

endpackage

/* sv/first_fit_boundary_tag_allocator_unit.sv */
// First-fit allocator over a pool of POOL_BYTES offsets, kept as boundary tags.
// The s_ channel takes one word per request: s_action selects allocate, free
// or clear, with s_request_size and s_release_offset as operands. The m_
// channel returns one word per request: m_ok and m_data_offset.
// An allocate walks the chunks from offset zero, with one tag memory read and
// one evaluation per chunk visited, then writes header, footer and, on a
// split, remainder tags. A free reads the header tag and marks an allocated
// chunk free; a clear sweeps the tag memory one entry a cycle.
// Requests are handled one at a time; the next word is taken once the result
// of the previous one has been registered.
// After reset the block sweeps the tag memory with s_ready low, leaving one
// free chunk at offset zero.
// A stalled receiver holds the result in the output register; the block
// still takes and works on one further request, then waits with its result
// until the output register is free.
module first_fit_boundary_tag_allocator_unit #(
    parameter int unsigned POOL_BYTES   = 512,
    parameter int unsigned HEADER_BYTES = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ffbta_pkg::ACT_W-1:0] s_action,
    input  logic [ffbta_pkg::REQ_W-1:0] s_request_size,
    input  logic [ffbta_pkg::OFF_W-1:0] s_release_offset,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [ffbta_pkg::OFF_W-1:0] m_data_offset
);
    import ffbta_pkg::*;

    cmd_t    cmd;
    status_t status;

    ffbta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    ffbta_datapath #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_action         (s_action),
        .s_request_size   (s_request_size),
        .s_release_offset (s_release_offset),
        .m_ok             (m_ok),
        .m_data_offset    (m_data_offset)
    );

endmodule

/* sv/ffbta_datapath.sv */
module ffbta_datapath #(
    parameter int unsigned POOL_BYTES   = 512,
    parameter int unsigned HEADER_BYTES = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ffbta_pkg::cmd_t            cmd,
    output ffbta_pkg::status_t         status,
    input  logic [ffbta_pkg::ACT_W-1:0] s_action,
    input  logic [ffbta_pkg::REQ_W-1:0] s_request_size,
    input  logic [ffbta_pkg::OFF_W-1:0] s_release_offset,
    output logic                       m_ok,
    output logic [ffbta_pkg::OFF_W-1:0] m_data_offset
);
    import ffbta_pkg::*;

    localparam int unsigned ADDR_W = $clog2(POOL_BYTES);
    localparam int unsigned SIZE_W = ADDR_W;
    localparam int unsigned TAG_W  = SIZE_W + 1;
    localparam int unsigned W      = ((ADDR_W > REQ_W) ? ADDR_W : REQ_W) + 2;
    localparam logic [W-1:0] POOL_W = W'(POOL_BYTES);
    localparam logic [W-1:0] HDR_W  = W'(HEADER_BYTES);
    localparam logic [W-1:0] HDR2_W = W'(2 * HEADER_BYTES);
    localparam logic [TAG_W-1:0] INIT_TAG = {1'b0, SIZE_W'(POOL_BYTES - HEADER_BYTES)};
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_BYTES - 1);

    logic [TAG_W-1:0]  tag_mem [POOL_BYTES];
    logic [TAG_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [W-1:0]      wr_addr_w;
    logic [TAG_W-1:0]  wr_tag;
    logic              wr_en;
    logic              mem_we;

    action_t           act_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [W-1:0]      ptr_reg;
    logic [SIZE_W-1:0] chunk_size_reg;
    logic              split_reg;
    logic [ADDR_W-1:0] clr_ptr_reg;
    logic [ADDR_W-1:0] clr_ptr_next;
    logic              m_ok_reg;
    logic [OFF_W-1:0]  m_data_offset_reg;

    logic [W-1:0]      size_w;
    logic [W-1:0]      req_w;
    logic [W-1:0]      data_w;
    logic [W-1:0]      next_ptr;
    logic [W-1:0]      wsize_w;
    logic [W-1:0]      ftr_addr_w;
    logic [W-1:0]      rest_addr_w;
    logic [W-1:0]      rest_size_w;
    logic [W-1:0]      off_w;
    logic [W-1:0]      free_hdr_w;
    logic              rd_alloc;
    logic              clr_last;

    assign rd_alloc    = rd_data_reg[SIZE_W];
    assign size_w      = W'(rd_data_reg[SIZE_W-1:0]);
    assign req_w       = W'(req_reg);
    assign data_w      = ptr_reg + HDR_W;
    assign next_ptr    = ptr_reg + size_w + HDR2_W;
    assign wsize_w     = split_reg ? req_w : W'(chunk_size_reg);
    assign ftr_addr_w  = data_w + wsize_w;
    assign rest_addr_w = data_w + req_w + HDR_W;
    assign rest_size_w = W'(chunk_size_reg) - req_w - HDR2_W;
    assign off_w       = W'(off_reg);
    assign free_hdr_w  = off_w - HDR_W;
    assign clr_last    = (clr_ptr_reg == LAST_ADDR);

    assign rd_addr = (act_reg == ACT_FREE) ? free_hdr_w[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];

    assign status.walk_end = (ptr_reg >= POOL_W);
    assign status.hit      = !rd_alloc && (size_w >= req_w) && (data_w < POOL_W);
    assign status.split    = split_reg;
    assign status.free_bad = (off_w < HDR_W) || (free_hdr_w >= POOL_W);
    assign status.rd_alloc = rd_alloc;
    assign status.clr_last = clr_last;

    always_comb begin
        wr_en     = 1'b0;
        wr_addr_w = '0;
        wr_tag    = '0;
        unique case (cmd.wr_sel)
            WR_NONE: begin
                wr_en = 1'b0;
            end
            WR_HDR: begin
                wr_en     = 1'b1;
                wr_addr_w = ptr_reg;
                wr_tag    = {1'b1, wsize_w[SIZE_W-1:0]};
            end
            WR_FTR: begin
                wr_en     = 1'b1;
                wr_addr_w = ftr_addr_w;
                wr_tag    = {1'b1, wsize_w[SIZE_W-1:0]};
            end
            WR_REST: begin
                wr_en     = 1'b1;
                wr_addr_w = rest_addr_w;
                wr_tag    = {1'b0, rest_size_w[SIZE_W-1:0]};
            end
            WR_FREE: begin
                wr_en     = 1'b1;
                wr_addr_w = free_hdr_w;
                wr_tag    = {1'b0, rd_data_reg[SIZE_W-1:0]};
            end
            WR_CLR: begin
                wr_en     = 1'b1;
                wr_addr_w = W'(clr_ptr_reg);
                wr_tag    = (clr_ptr_reg == '0) ? INIT_TAG : '0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign mem_we  = wr_en && (wr_addr_w < POOL_W);
    assign wr_addr = wr_addr_w[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_data_reg <= tag_mem[rd_addr];
    end

    always_comb begin
        clr_ptr_next = clr_ptr_reg;
        if (cmd.wr_sel == WR_CLR) begin
            clr_ptr_next = clr_last ? '0 : clr_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else begin
            clr_ptr_reg <= clr_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg <= action_t'(s_action);
            req_reg <= s_request_size;
            off_reg <= s_release_offset;
            ptr_reg <= '0;
        end else if (cmd.walk_adv) begin
            ptr_reg <= next_ptr;
        end
        if (cmd.hit_latch) begin
            chunk_size_reg <= rd_data_reg[SIZE_W-1:0];
            split_reg      <= (size_w >= req_w + HDR2_W);
        end
        if (cmd.res_load) begin
            m_ok_reg          <= cmd.res_ok;
            m_data_offset_reg <= (cmd.res_ok && act_reg == ACT_ALLOC) ? data_w[OFF_W-1:0] : '0;
        end
    end

    assign m_ok          = m_ok_reg;
    assign m_data_offset = m_data_offset_reg;

endmodule

/* sv/ffbta_ctrl.sv */
module ffbta_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ffbta_pkg::ACT_W-1:0] s_action,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ffbta_pkg::cmd_t             cmd,
    input  ffbta_pkg::status_t          status
);
    import ffbta_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    logic    ok_reg;
    logic    ok_next;
    logic    m_valid_reg;
    logic    m_valid_next;
    action_t in_act;

    assign in_act = action_t'(s_action);

    always_comb begin
        state_next = state_reg;
        ok_next    = ok_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    ok_next = (in_act == ACT_CLEAR);
                    unique case (in_act)
                        ACT_ALLOC: state_next = ST_ALLOC_RD;
                        ACT_FREE:  state_next = ST_FREE_RD;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_ALLOC_RD: begin
                state_next = status.walk_end ? ST_DONE : ST_ALLOC_EVAL;
            end
            ST_ALLOC_EVAL: begin
                if (status.hit) begin
                    ok_next    = 1'b1;
                    state_next = ST_WR_HDR;
                end else begin
                    state_next = ST_ALLOC_RD;
                end
            end
            ST_WR_HDR: begin
                state_next = ST_WR_FTR;
            end
            ST_WR_FTR: begin
                state_next = status.split ? ST_WR_REST : ST_DONE;
            end
            ST_WR_REST: begin
                state_next = ST_DONE;
            end
            ST_FREE_RD: begin
                state_next = status.free_bad ? ST_DONE : ST_FREE_EVAL;
            end
            ST_FREE_EVAL: begin
                ok_next    = status.rd_alloc;
                state_next = ST_DONE;
            end
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.wr_sel = WR_CLR;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_ALLOC_RD: begin
                cmd.wr_sel = WR_NONE;
            end
            ST_ALLOC_EVAL: begin
                cmd.hit_latch = status.hit;
                cmd.walk_adv  = !status.hit;
            end
            ST_WR_HDR: begin
                cmd.wr_sel = WR_HDR;
            end
            ST_WR_FTR: begin
                cmd.wr_sel = WR_FTR;
            end
            ST_WR_REST: begin
                cmd.wr_sel = WR_REST;
            end
            ST_FREE_RD: begin
                cmd.wr_sel = WR_NONE;
            end
            ST_FREE_EVAL: begin
                cmd.wr_sel = status.rd_alloc ? WR_FREE : WR_NONE;
            end
            ST_CLEAR: begin
                cmd.wr_sel = WR_CLR;
            end
            ST_DONE: begin
                cmd.res_load = !m_valid_reg || m_ready;
                cmd.res_ok   = ok_reg;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid_next = cmd.res_load || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ok_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ok_reg      <= ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word raised outside the completion state");

    a_no_result_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_INIT) |-> !m_valid_reg)
        else $error("result word pending during the reset sweep");

    a_rest_after_footer: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_REST) |-> ($past(state_reg) == ST_WR_FTR && status.split))
        else $error("remainder tag written without a split");

endmodule
